/* src/rwet_pkg.sv */
// Shared types and constants for the rolling window energy tracker.
// No dependencies; every other file of the block but rwet_ram uses this package.
package rwet_pkg;

  // Default depth of each snapshot window, in snapshot pairs
  localparam int HISTORY_POINTS_DEF = 49;

  // Field widths of the channel words
  localparam int WH_W     = 32;
  localparam int POINTS_W = 6;

  typedef logic [WH_W-1:0]     wh_t;
  typedef logic [POINTS_W-1:0] points_t;

  typedef enum logic [0:0] {
    CMD_REFRESH    = 1'b0,
    CMD_CHECKPOINT = 1'b1
  } cmd_t;

endpackage

/* src/rwet_if.sv */
// Valid/ready channel interfaces for the input and result words.
// Depends on rwet_pkg for field types.
interface rwet_in_if;
  logic          valid;
  logic          ready;
  rwet_pkg::cmd_t command;
  rwet_pkg::wh_t  pv_lifetime_wh;
  rwet_pkg::wh_t  charge_lifetime_wh;

  modport source (output valid, output command, output pv_lifetime_wh,
                  output charge_lifetime_wh, input ready);
  modport sink   (input valid, input command, input pv_lifetime_wh,
                  input charge_lifetime_wh, output ready);
endinterface

interface rwet_out_if;
  logic             valid;
  logic             ready;
  rwet_pkg::wh_t     pv_window_wh;
  rwet_pkg::wh_t     charge_window_wh;
  rwet_pkg::points_t points_held;

  modport source (output valid, output pv_window_wh, output charge_window_wh,
                  output points_held, input ready);
  modport sink   (input valid, input pv_window_wh, input charge_window_wh,
                  input points_held, output ready);
endinterface

/* src/rwet_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rwet_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 49
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/rolling_window_energy_tracker_top.sv */
// Top level of the rolling window energy tracker.
// Depends on rwet_pkg, rwet_if (channels) and rwet_ram (snapshot ring).
//
// Each input word yields one result word via the registered snapshot RAM read
// and then the saturating subtract into the output register; a new word is
// accepted every cycle while the result side keeps up. Snapshot pairs live
// in one ring RAM of HISTORY_POINTS entries; the oldest pair needed by a
// word is read on the same edge that stores its checkpoint, at a different
// address. Reset takes effect at once: no clearing pass is run, and only the
// initial zero entry is tracked with a flag until it is first overwritten.
module rolling_window_energy_tracker_top #(
  parameter int HISTORY_POINTS = rwet_pkg::HISTORY_POINTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rwet_in_if.sink    in_ch,
  rwet_out_if.source out_ch
);
  import rwet_pkg::*;

  localparam int SLOT_W = (HISTORY_POINTS > 1) ? $clog2(HISTORY_POINTS) : 1;
  localparam int CNT_W  = $clog2(HISTORY_POINTS + 1);
  localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(HISTORY_POINTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_POINTS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_POINTS);

  // Ring state
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              zero_written_r, zero_written_nxt;

  // Read stage
  logic              s1_valid_r, s1_valid_nxt;
  wh_t               s1_pv_r, s1_chg_r;
  logic [CNT_W-1:0]  s1_fill_r;
  logic              s1_rd_zero_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  wh_t               out_pv_r, out_chg_r;
  points_t           out_points_r;

  logic              s2_take, in_ready, in_fire, is_ckpt, full;
  logic [SLOT_W-1:0] oldest_inc, app_slot, wr_addr, rd_addr;
  logic [SLOT_W:0]   app_sum, app_wrap;
  logic              wr_en;
  logic [2*WH_W-1:0] rd_data;
  wh_t               pv_snap, chg_snap, pv_win, chg_win;

  always_comb begin
    s2_take  = !out_valid_r || out_ch.ready;
    in_ready = !s1_valid_r || s2_take;
    in_fire  = in_ch.valid && in_ready;
    is_ckpt  = (in_ch.command == CMD_CHECKPOINT);
    full     = (fill_r == FULL_CNT);

    oldest_inc = (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
    // Append slot: oldest + fill, wrapped once (both below depth)
    app_sum  = {1'b0, oldest_r} + {1'b0, fill_r[SLOT_W-1:0]};
    app_wrap = app_sum - DEPTH_EXT;
    app_slot = (app_sum >= DEPTH_EXT) ? app_wrap[SLOT_W-1:0] : app_sum[SLOT_W-1:0];

    wr_en   = in_fire && is_ckpt;
    wr_addr = full ? oldest_r : app_slot;
    // A full checkpoint drops the oldest pair, so the result needs the next one
    rd_addr = (is_ckpt && full) ? oldest_inc : oldest_r;

    oldest_nxt       = (wr_en && full) ? oldest_inc : oldest_r;
    fill_nxt         = (wr_en && !full) ? fill_r + 1'b1 : fill_r;
    zero_written_nxt = zero_written_r || (wr_en && (wr_addr == '0));

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s2_take ? s1_valid_r : out_valid_r;

    // Slot zero reads as zero until the first pair lands there
    pv_snap  = s1_rd_zero_r ? '0 : rd_data[WH_W-1:0];
    chg_snap = s1_rd_zero_r ? '0 : rd_data[2*WH_W-1:WH_W];
    pv_win   = (s1_pv_r >= pv_snap) ? s1_pv_r - pv_snap : '0;
    chg_win  = (s1_chg_r >= chg_snap) ? s1_chg_r - chg_snap : '0;
  end

  rwet_ram #(
    .WIDTH (2 * WH_W),
    .DEPTH (HISTORY_POINTS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_ch.charge_lifetime_wh, in_ch.pv_lifetime_wh}),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r       <= '0;
      fill_r         <= CNT_W'(1);
      zero_written_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      oldest_r       <= oldest_nxt;
      fill_r         <= fill_nxt;
      zero_written_r <= zero_written_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pv_r      <= in_ch.pv_lifetime_wh;
      s1_chg_r     <= in_ch.charge_lifetime_wh;
      s1_fill_r    <= fill_nxt;
      s1_rd_zero_r <= (rd_addr == '0) && !zero_written_r;
    end
    if (s2_take && s1_valid_r) begin
      out_pv_r     <= pv_win;
      out_chg_r    <= chg_win;
      out_points_r <= POINTS_W'(s1_fill_r);
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.pv_window_wh     = out_pv_r;
  assign out_ch.charge_window_wh = out_chg_r;
  assign out_ch.points_held      = out_points_r;

endmodule

/* src/rwet_chk.sv */
// Port-level assertions for the rolling window energy tracker, bound to the top.
// Depends on rwet_pkg and rolling_window_energy_tracker_top.
module rwet_chk #(
  parameter int HISTORY_POINTS = rwet_pkg::HISTORY_POINTS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input rwet_pkg::wh_t     pv_window_wh,
  input rwet_pkg::wh_t     charge_window_wh,
  input rwet_pkg::points_t points_held
);
  import rwet_pkg::*;

  localparam bit COUNT_FITS = (HISTORY_POINTS < 64);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pv_window_wh)
      && $stable(charge_window_wh) && $stable(points_held))
    else $error("result word changed while stalled");

  // Reset drops any pending result
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Window always holds between one and the full depth of pairs
  a_points_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && COUNT_FITS |-> points_held != '0
      && points_held <= POINTS_W'(HISTORY_POINTS))
    else $error("points_held out of range");

endmodule

bind rolling_window_energy_tracker_top rwet_chk #(
  .HISTORY_POINTS (HISTORY_POINTS)
) u_rwet_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .pv_window_wh     (out_ch.pv_window_wh),
  .charge_window_wh (out_ch.charge_window_wh),
  .points_held      (out_ch.points_held)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for rolling_window_energy_tracker_top: drives input words and checks every result word.
// Depends on rwet_pkg and the channel interfaces in rwet_if; a local window tracker predicts results.
module tb;
  import rwet_pkg::*;

  localparam int HIST         = HISTORY_POINTS_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    wh_t     pv_window;
    wh_t     charge_window;
    points_t points;
  } window_word_t;

  logic clk;
  logic rst_n;

  rwet_in_if  in_ch ();
  rwet_out_if out_ch ();

  rolling_window_energy_tracker_top #(.HISTORY_POINTS(HIST)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the snapshot ring, one array per counter
  wh_t         pv_ring [HIST];
  wh_t         charge_ring [HIST];
  int unsigned pairs_held;
  int unsigned oldest_pair;

  window_word_t pending_windows[$];

  int errors;
  int cycle_count;
  int burst_left;
  int gap_max;
  int stall_pct;
  int hold_req;
  int hold_left;
  int stall_left;
  wh_t pv_run;
  wh_t charge_run;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Update the local rings for one accepted word and queue its result.
  function automatic void predict_window(cmd_t cmd, wh_t pv, wh_t chg);
    int unsigned  slot;
    window_word_t w;
    if (cmd == CMD_CHECKPOINT) begin
      if (pairs_held < HIST) begin
        slot = (oldest_pair + pairs_held) % HIST;
        pairs_held++;
      end else begin
        // full: overwrite the oldest pair and advance
        slot = oldest_pair;
        oldest_pair = (oldest_pair + 1) % HIST;
      end
      pv_ring[slot]     = pv;
      charge_ring[slot] = chg;
    end
    w.pv_window     = (pv >= pv_ring[oldest_pair]) ? pv - pv_ring[oldest_pair] : '0;
    w.charge_window = (chg >= charge_ring[oldest_pair]) ?
                      chg - charge_ring[oldest_pair] : '0;
    w.points        = points_t'(pairs_held);
    pending_windows.push_back(w);
  endfunction

  always @(posedge clk) begin
    window_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_windows.size() == 0) begin
        $error("result word with no window pending");
        errors++;
      end else begin
        want = pending_windows.pop_front();
        if (out_ch.pv_window_wh !== want.pv_window) begin
          $error("pv_window_wh expected %0d actual %0d", want.pv_window, out_ch.pv_window_wh);
          errors++;
        end
        if (out_ch.charge_window_wh !== want.charge_window) begin
          $error("charge_window_wh expected %0d actual %0d", want.charge_window,
                 out_ch.charge_window_wh);
          errors++;
        end
        if (out_ch.points_held !== want.points) begin
          $error("points_held expected %0d actual %0d", want.points, out_ch.points_held);
          errors++;
        end
      end
    end
  end

  // Receiver: long holds on request, otherwise short random stall runs.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic set_traffic(input int stall, input int gap);
    stall_pct  = stall;
    gap_max    = gap;
    burst_left = 0;
  endtask

  // Offer one word, hold it until accepted, then maybe open a gap.
  task automatic send_word(input cmd_t cmd, input wh_t pv, input wh_t chg);
    in_ch.valid              <= 1'b1;
    in_ch.command            <= cmd;
    in_ch.pv_lifetime_wh     <= pv;
    in_ch.charge_lifetime_wh <= chg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_window(cmd, pv, chg);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly rising totals with random steps; the rest is full-range noise or dips.
  task automatic send_energy_run(input int count, input int ckpt_pct);
    int   roll;
    cmd_t cmd;
    wh_t  pv;
    wh_t  chg;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        pv_run     += $urandom_range(0, 4000);
        charge_run += $urandom_range(0, 3000);
        pv  = pv_run;
        chg = charge_run;
      end else if (roll < 90) begin
        pv  = $urandom;
        chg = $urandom;
      end else begin
        // dip each window with even odds, often below the oldest snapshot
        pv  = $urandom_range(0, 1) ? wh_t'($urandom_range(0, pv_run)) : pv_run;
        chg = $urandom_range(0, 1) ? wh_t'($urandom_range(0, charge_run)) : charge_run;
      end
      cmd = ($urandom_range(0, 99) < ckpt_pct) ? CMD_CHECKPOINT : CMD_REFRESH;
      send_word(cmd, pv, chg);
    end
  endtask

  task automatic test_reset_extremes();
    set_traffic(20, 3);
    send_word(CMD_REFRESH, 32'h0, 32'h0);
    send_word(CMD_REFRESH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_REFRESH, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(CMD_CHECKPOINT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(CMD_CHECKPOINT, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_REFRESH, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_CHECKPOINT, 32'h0, 32'h0);
    send_word(CMD_REFRESH, 32'h1, 32'h1);
  endtask

  // Fill the window with rising checkpoints and keep going so the ring wraps.
  task automatic test_window_fill();
    set_traffic(0, 0);
    pv_run     = 32'd1000;
    charge_run = 32'd500;
    repeat (HIST + 25) begin
      pv_run     += $urandom_range(1, 5000);
      charge_run += $urandom_range(1, 5000);
      send_word(CMD_CHECKPOINT, pv_run, charge_run);
    end
  endtask

  // Totals below, at and above the oldest snapshot, each window on its own.
  task automatic test_below_snapshot();
    wh_t pv_old;
    wh_t chg_old;
    set_traffic(30, 4);
    wait_drain();
    pv_old  = pv_ring[oldest_pair];
    chg_old = charge_ring[oldest_pair];
    send_word(CMD_REFRESH, pv_old - 1, chg_old + 1);
    send_word(CMD_REFRESH, pv_old + 1, chg_old - 1);
    send_word(CMD_REFRESH, pv_old - 1, chg_old - 1);
    send_word(CMD_REFRESH, pv_old, chg_old);
    send_word(CMD_REFRESH, 32'h0, 32'hFFFF_FFFF);
    // full-window checkpoint below every snapshot
    send_word(CMD_CHECKPOINT, 32'h0, 32'h0);
    send_word(CMD_REFRESH, pv_run, charge_run);
    send_word(CMD_CHECKPOINT, pv_run, charge_run);
  endtask

  // Hold the receiver off while words keep coming so the input stalls.
  task automatic test_backpressure();
    set_traffic(0, 0);
    hold_req = 200;
    send_energy_run(40, 30);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    set_traffic(0, 0);
    send_energy_run(200, 25);
    set_traffic(30, 6);
    send_energy_run(300, 25);
    set_traffic(70, 2);
    send_energy_run(250, 40);
    wait_drain();
    set_traffic(10, 12);
    send_energy_run(250, 10);
    // run the totals past the top of the counter
    pv_run     = 32'hFFFF_F000;
    charge_run = 32'hFFFF_F800;
    set_traffic(40, 4);
    send_energy_run(150, 30);
    set_traffic(50, 0);
    send_energy_run(350, 25);
  endtask

  initial begin
    errors      = 0;
    cycle_count = 0;
    hold_req    = 0;
    hold_left   = 0;
    stall_left  = 0;
    stall_pct   = 0;
    gap_max     = 0;
    burst_left  = 0;
    pairs_held  = 1;
    oldest_pair = 0;
    pv_run      = '0;
    charge_run  = '0;
    for (int i = 0; i < HIST; i++) begin
      pv_ring[i]     = '0;
      charge_ring[i] = '0;
    end
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.command            = CMD_REFRESH;
    in_ch.pv_lifetime_wh     = '0;
    in_ch.charge_lifetime_wh = '0;
    out_ch.ready             = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_extremes();
    test_window_fill();
    test_below_snapshot();
    test_backpressure();
    test_random_traffic();
    wait_drain();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* rolling_window_energy_tracker_top.f */
src/rwet_pkg.sv
src/rwet_if.sv
src/rwet_ram.sv
src/rolling_window_energy_tracker_top.sv
src/rwet_chk.sv
bench/tb.sv
